### design/afa_pkg.sv
// Shared types, codes and helper functions for the aligned bitmap frame allocator.
// No dependencies; every other design file but afa_ram refers to this package by scoped names.
`default_nettype none

package afa_pkg;

	localparam int ROW_BITS = 64;
	localparam logic [ROW_BITS-1:0] ROW_ONES = {ROW_BITS{1'b1}};

	localparam logic [1:0] MODE_ALLOC  = 2'd0;
	localparam logic [1:0] MODE_TOGGLE = 2'd1;
	localparam logic [1:0] MODE_QUERY  = 2'd2;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_NO_RUN   = 2'd1;
	localparam logic [1:0] STAT_MISMATCH = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_FILL,
		ST_FIN
	} state_t;

	// Run of 2^order ones starting at bit pos, bits above the row end dropped.
	function automatic logic [ROW_BITS-1:0] run_mask(input logic [2:0] order,
			input logic [5:0] pos);
		logic [6:0] len;
		len = 7'd1 << order;
		return (ROW_ONES >> (7'd64 - len)) << pos;
	endfunction

	// Remainder of a narrow value by a small divisor, by repeated subtraction.
	function automatic logic [2:0] mod_small(input logic [2:0] v, input logic [6:0] m);
		logic [2:0] r;
		r = v;
		for (int n = 0; n < 8; n++) begin
			if ({4'd0, r} >= m) begin
				r = r - m[2:0];
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### design/afa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module afa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8
) (
	input  wire logic                                 clk,
	input  wire logic                                 we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                     wdata,
	input  wire logic                                 re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### design/afa_row_store.sv
// Bitmap row store: one RAM row per 64 frames plus a written flag per row.
// A row never written since reset reads as all zero. Depends on afa_pkg and afa_ram.
`default_nettype none

module afa_row_store #(
	parameter int FIELD_ROWS = 8
) (
	input  wire logic                                           clk,
	input  wire logic                                           arst_n,
	input  wire logic                                           rd_en,
	input  wire logic [(FIELD_ROWS > 1 ? $clog2(FIELD_ROWS) : 1)-1:0] rd_addr,
	input  wire logic                                           wr_en,
	input  wire logic [(FIELD_ROWS > 1 ? $clog2(FIELD_ROWS) : 1)-1:0] wr_addr,
	input  wire logic [afa_pkg::ROW_BITS-1:0]                   wr_data,
	output logic      [afa_pkg::ROW_BITS-1:0]                   rd_data
);

	logic [FIELD_ROWS-1:0]        written_q;
	logic                         rd_written_q;
	logic [afa_pkg::ROW_BITS-1:0] ram_rdata;

	afa_ram #(
		.WIDTH(afa_pkg::ROW_BITS),
		.DEPTH(FIELD_ROWS)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			rd_written_q <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_written_q <= written_q[rd_addr];
			end
		end
	end

	// Mask rows that still hold their reset value
	assign rd_data = rd_written_q ? ram_rdata : '0;

endmodule

`default_nettype wire

### design/afa_chunk_find.sv
// Finds the lowest naturally aligned all-zero chunk of 2^order bits in one row.
// Depends on afa_pkg.
`default_nettype none

module afa_chunk_find (
	input  wire logic [afa_pkg::ROW_BITS-1:0] row,
	input  wire logic [2:0]                   order,
	output logic                              found,
	output logic [5:0]                        pos,
	output logic [afa_pkg::ROW_BITS-1:0]      mask
);

	logic [afa_pkg::ROW_BITS-1:0] free_o [7];
	logic [afa_pkg::ROW_BITS-1:0] sel;

	always_comb begin
		for (int o = 0; o < 7; o++) begin
			for (int p = 0; p < afa_pkg::ROW_BITS; p++) begin
				if ((p & ((1 << o) - 1)) == 0) begin
					free_o[o][p] = (row & afa_pkg::run_mask(3'(o), 6'(p))) == '0;
				end else begin
					free_o[o][p] = 1'b0;
				end
			end
		end
	end

	always_comb begin
		if (order < 3'd7) begin
			sel = free_o[order];
		end else begin
			sel = '0;
		end
	end

	// Lowest candidate wins
	always_comb begin
		pos = '0;
		for (int p = afa_pkg::ROW_BITS - 1; p >= 0; p--) begin
			if (sel[p]) begin
				pos = 6'(p);
			end
		end
	end

	assign found = |sel;
	assign mask  = afa_pkg::run_mask(order, pos);

endmodule

`default_nettype wire

### design/aligned_bitmap_frame_allocator.sv
// Flow from transfer to strobe: query and toggle of up to 64 frames go through READ, EVAL and FIN;
// mode 3 and allocate requests rejected outright go straight to FIN. Each further row visited
// adds a READ and an EVAL; each row filled adds a FILL, and a toggle past the field ends in READ.
// One item at a time: busy stays high through the strobe, so the next transfer comes after it.
// Reset: asynchronous; bitmap reads as all free through per-row written flags, count is zero.
// Depends on afa_pkg, afa_row_store and afa_chunk_find.
`default_nettype none

module aligned_bitmap_frame_allocator #(
	parameter int FIELD_ROWS = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [1:0] mode,
	input  wire logic [8:0] frame_index,
	input  wire logic [3:0] block_order,
	input  wire logic       expected_set,
	output logic            done,
	output logic [1:0]      status,
	output logic [8:0]      result_frame,
	output logic            is_free,
	output logic [9:0]      allocated_count
);

	localparam int RW = (FIELD_ROWS > 1) ? $clog2(FIELD_ROWS) : 1;
	localparam int IW = $clog2(FIELD_ROWS + 1);
	localparam logic [IW-1:0] ROWS_N  = IW'(FIELD_ROWS);
	localparam logic [IW-1:0] GROUPS7 = IW'(FIELD_ROWS / 2);
	localparam logic [IW-1:0] GROUPS8 = IW'(FIELD_ROWS / 4);

	afa_pkg::state_t state_q, state_d;

	logic [1:0]    mode_q, mode_d;
	logic [3:0]    order_q, order_d;
	logic          exp_q, exp_d;
	logic [5:0]    bit_q, bit_d;
	logic [IW-1:0] row_q, row_d;
	logic [IW-1:0] k_q, k_d;
	logic [9:0]    i_q, i_d;
	logic [RW-1:0] g_q, g_d;
	logic [1:0]    status_q, status_d;
	logic [8:0]    frame_q, frame_d;
	logic          free_q, free_d;
	logic [9:0]    count_q, count_d;

	logic                         rd_en, wr_en;
	logic [afa_pkg::ROW_BITS-1:0] rd_data, wr_data;

	// Transfer-side decode
	logic [2:0]    in_row3, in_hint, in_g0;
	logic [IW-1:0] in_groups, in_base;

	// Evaluate-side decode
	logic [IW-1:0]                groups_q, g_next, base_next, base_cur;
	logic [RW-1:0]                g_inc;
	logic [9:0]                   entries_q;
	logic [afa_pkg::ROW_BITS-1:0] tog_mask, want_row;
	logic [6:0]                   len_q, room_q, tog_cnt;
	logic                         cf_found;
	logic [5:0]                   cf_pos;
	logic [afa_pkg::ROW_BITS-1:0] cf_mask;

	afa_row_store #(
		.FIELD_ROWS(FIELD_ROWS)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (rd_en),
		.rd_addr(row_q[RW-1:0]),
		.wr_en  (wr_en),
		.wr_addr(row_q[RW-1:0]),
		.wr_data(wr_data),
		.rd_data(rd_data)
	);

	afa_chunk_find u_find (
		.row  (rd_data),
		.order(order_q[2:0]),
		.found(cf_found),
		.pos  (cf_pos),
		.mask (cf_mask)
	);

	assign in_row3   = afa_pkg::mod_small(frame_index[8:6], 7'(FIELD_ROWS));
	assign in_groups = (block_order == 4'd7) ? GROUPS7 : GROUPS8;
	assign in_hint   = (block_order == 4'd7) ? (in_row3 >> 1) : (in_row3 >> 2);
	assign in_g0     = afa_pkg::mod_small(in_hint, 7'(in_groups));
	assign in_base   = (block_order == 4'd7) ? (IW'(in_g0) << 1) : (IW'(in_g0) << 2);

	assign groups_q  = (order_q == 4'd7) ? GROUPS7 : GROUPS8;
	assign g_inc     = g_q + 1'b1;
	assign g_next    = (IW'(g_q) + 1'b1 == groups_q) ? '0 : IW'(g_inc);
	assign base_next = (order_q == 4'd7) ? (g_next << 1) : (g_next << 2);
	assign base_cur  = (order_q == 4'd7) ? (IW'(g_q) << 1) : (IW'(g_q) << 2);
	assign entries_q = 10'd1 << (order_q - 4'd6);
	assign tog_mask  = afa_pkg::run_mask(order_q[2:0], bit_q);
	assign want_row  = {afa_pkg::ROW_BITS{exp_q}};
	assign len_q     = 7'd1 << order_q[2:0];
	assign room_q    = 7'd64 - {1'b0, bit_q};
	assign tog_cnt   = (len_q < room_q) ? len_q : room_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= afa_pkg::ST_IDLE;
			mode_q   <= afa_pkg::MODE_ALLOC;
			order_q  <= '0;
			exp_q    <= 1'b0;
			bit_q    <= '0;
			row_q    <= '0;
			k_q      <= '0;
			i_q      <= '0;
			g_q      <= '0;
			status_q <= afa_pkg::STAT_OK;
			frame_q  <= '0;
			free_q   <= 1'b0;
			count_q  <= '0;
		end else begin
			state_q  <= state_d;
			mode_q   <= mode_d;
			order_q  <= order_d;
			exp_q    <= exp_d;
			bit_q    <= bit_d;
			row_q    <= row_d;
			k_q      <= k_d;
			i_q      <= i_d;
			g_q      <= g_d;
			status_q <= status_d;
			frame_q  <= frame_d;
			free_q   <= free_d;
			count_q  <= count_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		mode_d   = mode_q;
		order_d  = order_q;
		exp_d    = exp_q;
		bit_d    = bit_q;
		row_d    = row_q;
		k_d      = k_q;
		i_d      = i_q;
		g_d      = g_q;
		status_d = status_q;
		frame_d  = frame_q;
		free_d   = free_q;
		count_d  = count_q;
		rd_en    = 1'b0;
		wr_en    = 1'b0;
		wr_data  = rd_data;

		unique case (state_q)
			afa_pkg::ST_IDLE: begin
				if (start) begin
					mode_d   = mode;
					order_d  = block_order;
					exp_d    = expected_set;
					bit_d    = frame_index[5:0];
					row_d    = IW'(in_row3);
					k_d      = '0;
					i_d      = '0;
					g_d      = '0;
					status_d = afa_pkg::STAT_OK;
					frame_d  = '0;
					free_d   = 1'b0;
					state_d  = afa_pkg::ST_READ;
					unique case (mode) inside
						afa_pkg::MODE_ALLOC: begin
							if (block_order > 4'd8) begin
								status_d = afa_pkg::STAT_NO_RUN;
								state_d  = afa_pkg::ST_FIN;
							end else if (block_order > 4'd6) begin
								if (in_groups == '0) begin
									status_d = afa_pkg::STAT_NO_RUN;
									state_d  = afa_pkg::ST_FIN;
								end else begin
									g_d   = RW'(in_g0);
									row_d = in_base;
								end
							end
						end
						afa_pkg::MODE_TOGGLE, afa_pkg::MODE_QUERY: begin
						end
						default: begin
							state_d = afa_pkg::ST_FIN;
						end
					endcase
				end
			end

			afa_pkg::ST_READ: begin
				// A multi-row toggle that runs off the end of the field fails here
				if (mode_q == afa_pkg::MODE_TOGGLE && order_q > 4'd6 && row_q == ROWS_N) begin
					status_d = afa_pkg::STAT_MISMATCH;
					state_d  = afa_pkg::ST_FIN;
				end else begin
					rd_en   = 1'b1;
					state_d = afa_pkg::ST_EVAL;
				end
			end

			afa_pkg::ST_EVAL: begin
				state_d = afa_pkg::ST_FIN;
				if (mode_q == afa_pkg::MODE_QUERY) begin
					free_d = ~rd_data[bit_q];
				end else if (mode_q == afa_pkg::MODE_TOGGLE) begin
					if (order_q <= 4'd6) begin
						if (exp_q && (rd_data & tog_mask) == tog_mask) begin
							wr_en   = 1'b1;
							wr_data = rd_data & ~tog_mask;
							count_d = count_q - 10'(tog_cnt);
						end else if (!exp_q && (rd_data & tog_mask) == '0) begin
							wr_en   = 1'b1;
							wr_data = rd_data | tog_mask;
							count_d = count_q + 10'(tog_cnt);
						end else begin
							status_d = afa_pkg::STAT_MISMATCH;
						end
					end else if (rd_data != want_row) begin
						status_d = afa_pkg::STAT_MISMATCH;
					end else begin
						wr_en   = 1'b1;
						wr_data = ~want_row;
						count_d = exp_q ? count_q - 10'd64 : count_q + 10'd64;
						if (i_q + 1'b1 != entries_q) begin
							i_d     = i_q + 1'b1;
							row_d   = row_q + 1'b1;
							state_d = afa_pkg::ST_READ;
						end
					end
				end else if (order_q <= 4'd6) begin
					if (cf_found) begin
						wr_en   = 1'b1;
						wr_data = rd_data | cf_mask;
						frame_d = {3'(row_q), cf_pos};
						count_d = count_q + 10'(len_q);
					end else if (k_q + 1'b1 == ROWS_N) begin
						status_d = afa_pkg::STAT_NO_RUN;
					end else begin
						// Advance to the next row, wrapping at the end of the field
						k_d     = k_q + 1'b1;
						row_d   = (row_q + 1'b1 == ROWS_N) ? '0 : row_q + 1'b1;
						state_d = afa_pkg::ST_READ;
					end
				end else if (rd_data != '0) begin
					if (k_q + 1'b1 == groups_q) begin
						status_d = afa_pkg::STAT_NO_RUN;
					end else begin
						k_d     = k_q + 1'b1;
						g_d     = RW'(g_next);
						row_d   = base_next;
						i_d     = '0;
						state_d = afa_pkg::ST_READ;
					end
				end else if (i_q + 1'b1 == entries_q) begin
					// Whole group clear: go back to its first row and fill
					i_d     = '0;
					row_d   = base_cur;
					frame_d = {3'(base_cur), 6'd0};
					state_d = afa_pkg::ST_FILL;
				end else begin
					i_d     = i_q + 1'b1;
					row_d   = row_q + 1'b1;
					state_d = afa_pkg::ST_READ;
				end
			end

			afa_pkg::ST_FILL: begin
				wr_en   = 1'b1;
				wr_data = afa_pkg::ROW_ONES;
				count_d = count_q + 10'd64;
				if (i_q + 1'b1 == entries_q) begin
					state_d = afa_pkg::ST_FIN;
				end else begin
					i_d   = i_q + 1'b1;
					row_d = row_q + 1'b1;
				end
			end

			afa_pkg::ST_FIN: begin
				state_d = afa_pkg::ST_IDLE;
			end

			default: begin
				state_d = afa_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy            = (state_q != afa_pkg::ST_IDLE);
	assign done            = (state_q == afa_pkg::ST_FIN);
	assign status          = status_q;
	assign result_frame    = frame_q;
	assign is_free         = free_q;
	assign allocated_count = count_q;

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe lasted more than one cycle");

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("transfer taken without raising busy");

	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !wr_en)
		else $error("row read and row write in the same cycle");

	a_free_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && is_free) |-> (status == afa_pkg::STAT_OK))
		else $error("free frame reported with a failing status");

	a_frame_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != afa_pkg::STAT_OK) |-> (result_frame == 9'd0))
		else $error("frame reported on a failed request");

endmodule

`default_nettype wire

### test/frame_alloc_checker.sv
// Checker for the aligned bitmap frame allocator: keeps its own copy of the frame bitmap,
// predicts each result on a request transfer and compares it on the done strobe.
// Depends on afa_pkg for the mode and status codes.

module frame_alloc_checker #(
	parameter int FIELD_ROWS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       busy,
	input  logic [1:0] mode,
	input  logic [8:0] frame_index,
	input  logic [3:0] block_order,
	input  logic       expected_set,
	input  logic       done,
	input  logic [1:0] status,
	input  logic [8:0] result_frame,
	input  logic       is_free,
	input  logic [9:0] allocated_count,
	output int         pending,
	output int         errors,
	output int         checked
);

	typedef struct packed {
		logic [1:0] status;
		logic [8:0] frame;
		logic       is_free;
		logic [9:0] count;
	} alloc_result_t;

	localparam logic [63:0] FULL_ROW = {64{1'b1}};

	logic [63:0]   shadow_rows [FIELD_ROWS];
	alloc_result_t expected_results [$];
	alloc_result_t oldest;

	// Apply one request to the shadow bitmap and return the result it should give.
	function automatic alloc_result_t apply_request(input logic [1:0] m, input logic [8:0] idx,
			input logic [3:0] ord, input logic free_run);
		alloc_result_t res;
		int row, bpos, len, entries, groups, g0, g, r, total;
		logic [63:0] run, mask, want;
		logic found, clear;
		res = '0;
		row = idx / 64;
		bpos = idx % 64;
		found = 1'b0;
		if (m == afa_pkg::MODE_ALLOC) begin
			if (ord > 8) begin
				res.status = afa_pkg::STAT_NO_RUN;
			end else if (ord <= 6) begin
				len = 1 << ord;
				run = (len == 64) ? FULL_ROW : ((64'd1 << len) - 64'd1);
				for (int k = 0; k < FIELD_ROWS && !found; k++) begin
					r = (row + k) % FIELD_ROWS;
					for (int p = 0; p < 64 && !found; p += len) begin
						if (((shadow_rows[r] >> p) & run) == 64'd0) begin
							shadow_rows[r] |= run << p;
							res.frame = 9'(r * 64 + p);
							found = 1'b1;
						end
					end
				end
				res.status = found ? afa_pkg::STAT_OK : afa_pkg::STAT_NO_RUN;
			end else begin
				// whole rows: only groups whose rows are all clear
				entries = 1 << (ord - 6);
				groups = FIELD_ROWS / entries;
				if (groups != 0) begin
					g0 = (row / entries) % groups;
					for (int k = 0; k < groups && !found; k++) begin
						g = (g0 + k) % groups;
						clear = 1'b1;
						for (int i = 0; i < entries; i++)
							if (shadow_rows[g * entries + i] != 64'd0)
								clear = 1'b0;
						if (clear) begin
							for (int i = 0; i < entries; i++)
								shadow_rows[g * entries + i] = FULL_ROW;
							res.frame = 9'(g * entries * 64);
							found = 1'b1;
						end
					end
				end
				res.status = found ? afa_pkg::STAT_OK : afa_pkg::STAT_NO_RUN;
			end
		end else if (m == afa_pkg::MODE_TOGGLE) begin
			if (ord > 6) begin
				// walk rows from the index row; rows already inverted stay inverted
				entries = 1 << (ord - 6);
				want = free_run ? FULL_ROW : 64'd0;
				for (int i = 0; i < entries && res.status == afa_pkg::STAT_OK; i++) begin
					if (row + i >= FIELD_ROWS || shadow_rows[row + i] != want)
						res.status = afa_pkg::STAT_MISMATCH;
					else
						shadow_rows[row + i] = ~want;
				end
			end else begin
				len = 1 << ord;
				mask = (FULL_ROW >> (64 - len)) << bpos;
				if (free_run) begin
					if ((shadow_rows[row] & mask) != mask)
						res.status = afa_pkg::STAT_MISMATCH;
					else
						shadow_rows[row] &= ~mask;
				end else begin
					if ((shadow_rows[row] & mask) != 64'd0)
						res.status = afa_pkg::STAT_MISMATCH;
					else
						shadow_rows[row] |= mask;
				end
			end
		end else if (m == afa_pkg::MODE_QUERY) begin
			res.is_free = ~shadow_rows[row][bpos];
		end
		total = 0;
		for (int i = 0; i < FIELD_ROWS; i++)
			total += $countones(shadow_rows[i]);
		res.count = 10'(total);
		return res;
	endfunction

	task automatic check_field(input string name, input logic [9:0] want_v,
			input logic [9:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FIELD_ROWS; i++)
				shadow_rows[i] = '0;
			expected_results.delete();
			pending = 0;
			errors = 0;
			checked = 0;
		end else begin
			if (done) begin
				if (expected_results.size() == 0) begin
					$error("result strobe with no request outstanding");
					errors++;
				end else begin
					oldest = expected_results.pop_front();
					check_field("status", 10'(oldest.status), 10'(status));
					check_field("result_frame", 10'(oldest.frame), 10'(result_frame));
					check_field("is_free", 10'(oldest.is_free), 10'(is_free));
					check_field("allocated_count", oldest.count, allocated_count);
					checked++;
				end
			end
			if (start && !busy)
				expected_results.push_back(apply_request(mode, frame_index, block_order,
						expected_set));
			pending = expected_results.size();
		end
	end

endmodule

### test/tb_aligned_bitmap_frame_allocator.sv
// Testbench top for the aligned bitmap frame allocator: drives directed and random requests,
// watches for stalls and reports the verdict. Depends on afa_pkg, frame_alloc_checker and the RTL.

module tb_aligned_bitmap_frame_allocator;

	localparam int          FIELD_ROWS     = 8;
	localparam int          RANDOM_ITEMS   = 825;
	localparam int          WATCHDOG_LIMIT = 2000;
	localparam logic [1:0]  MODE_UNUSED    = 2'd3;
	localparam logic [1:0]  M_ALLOC        = afa_pkg::MODE_ALLOC;
	localparam logic [1:0]  M_TOGGLE       = afa_pkg::MODE_TOGGLE;
	localparam logic [1:0]  M_QUERY        = afa_pkg::MODE_QUERY;

	typedef struct {
		logic [8:0] frame;
		logic [3:0] order;
	} held_run_t;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [1:0] mode;
	logic [8:0] frame_index;
	logic [3:0] block_order;
	logic       expected_set;
	logic       done;
	logic [1:0] status;
	logic [8:0] result_frame;
	logic       is_free;
	logic [9:0] allocated_count;

	int pending, fail_count, checked_count;
	logic took;
	int quiet_cycles;
	int mode_seen [4];
	int no_run_seen, mismatch_seen;
	logic [1:0] last_mode;
	logic [8:0] last_index;
	logic [3:0] last_order;
	logic       last_set;
	held_run_t  live_runs [$];

	aligned_bitmap_frame_allocator #(.FIELD_ROWS(FIELD_ROWS)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.frame_index(frame_index), .block_order(block_order), .expected_set(expected_set),
		.done(done), .status(status), .result_frame(result_frame), .is_free(is_free),
		.allocated_count(allocated_count)
	);

	frame_alloc_checker #(.FIELD_ROWS(FIELD_ROWS)) u_check (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.frame_index(frame_index), .block_order(block_order), .expected_set(expected_set),
		.done(done), .status(status), .result_frame(result_frame), .is_free(is_free),
		.allocated_count(allocated_count), .pending(pending), .errors(fail_count),
		.checked(checked_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			took <= 1'b0;
		end else begin
			took <= start && !busy;
		end
	end

	// Track runs that are held so the stimulus can hand them back later.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (status == afa_pkg::STAT_NO_RUN)
				no_run_seen++;
			if (status == afa_pkg::STAT_MISMATCH)
				mismatch_seen++;
			if (status == afa_pkg::STAT_OK && last_mode == M_ALLOC)
				live_runs.push_back('{frame: result_frame, order: last_order});
			if (status == afa_pkg::STAT_OK && last_mode == M_TOGGLE && !last_set)
				live_runs.push_back('{frame: last_index, order: last_order});
		end
		if (arst_n && start && !busy) begin
			last_mode = mode;
			last_index = frame_index;
			last_order = block_order;
			last_set = expected_set;
			mode_seen[mode]++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Present a request and hold it until the transfer.
	task automatic send_item(input logic [1:0] m, input logic [8:0] idx, input logic [3:0] ord,
			input logic es);
		start = 1'b1;
		mode = m;
		frame_index = idx;
		block_order = ord;
		expected_set = es;
		do @(negedge clk); while (!took);
	endtask

	task automatic maybe_idle(input bit allowed);
		if (allowed && $urandom_range(99) < 18) begin
			start = 1'b0;
			repeat ($urandom_range(1, 24)) @(negedge clk);
		end
	endtask

	task automatic drain();
		start = 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	function automatic logic [3:0] pick_order();
		int x;
		x = $urandom_range(99);
		if (x < 80)
			return 4'($urandom_range(0, 6));
		else if (x < 94)
			return 4'($urandom_range(7, 8));
		return 4'($urandom_range(9, 15));
	endfunction

	task automatic random_request();
		int sel, pick;
		logic [3:0] ord;
		logic [8:0] idx;
		held_run_t held;
		sel = $urandom_range(99);
		ord = pick_order();
		idx = 9'($urandom_range(511));
		if (sel < 34 || (sel < 64 && live_runs.size() == 0)) begin
			send_item(M_ALLOC, idx, ord, 1'($urandom_range(1)));
		end else if (sel < 64) begin
			// hand back a run that is held
			pick = $urandom_range(live_runs.size() - 1);
			held = live_runs[pick];
			live_runs.delete(pick);
			send_item(M_TOGGLE, held.frame, held.order, 1'b1);
		end else if (sel < 74) begin
			if (ord > 8)
				ord = 4'($urandom_range(0, 6));
			if (ord <= 6)
				idx = idx & ~9'((1 << ord) - 1);
			else
				idx = {idx[8:6], 6'd0};
			send_item(M_TOGGLE, idx, ord, 1'b0);
		end else if (sel < 89) begin
			send_item(M_QUERY, idx, 4'($urandom_range(15)), 1'($urandom_range(1)));
		end else if (sel < 98) begin
			send_item(M_TOGGLE, idx, 4'($urandom_range(15)), 1'($urandom_range(1)));
		end else begin
			send_item(MODE_UNUSED, idx, 4'($urandom_range(15)), 1'($urandom_range(1)));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		mode = M_ALLOC;
		frame_index = '0;
		block_order = '0;
		expected_set = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_item(M_QUERY, 9'd0, 4'd0, 1'b0);
		send_item(M_QUERY, 9'd511, 4'd15, 1'b1);
		send_item(M_ALLOC, 9'd0, 4'd0, 1'b0);
		send_item(M_ALLOC, 9'd511, 4'd6, 1'b0);
		send_item(M_ALLOC, 9'd130, 4'd7, 1'b0);
		// hint wraps onto the lower group, which is partly used
		send_item(M_ALLOC, 9'd300, 4'd8, 1'b0);
		send_item(M_ALLOC, 9'd0, 4'd9, 1'b0);
		send_item(M_ALLOC, 9'd511, 4'd15, 1'b1);
		send_item(M_TOGGLE, 9'd128, 4'd7, 1'b1);
		// run spills past the row end
		send_item(M_TOGGLE, 9'd60, 4'd3, 1'b0);
		send_item(M_TOGGLE, 9'd60, 4'd3, 1'b1);
		// first row changes, second does not match
		send_item(M_TOGGLE, 9'd384, 4'd7, 1'b0);
		// last row inverted, then runs off the field
		send_item(M_TOGGLE, 9'd500, 4'd7, 1'b1);
		send_item(M_TOGGLE, 9'd0, 4'd0, 1'b1);
		send_item(M_TOGGLE, 9'd0, 4'd0, 1'b1);
		send_item(M_TOGGLE, 9'd0, 4'd15, 1'b0);
		send_item(M_TOGGLE, 9'd0, 4'd15, 1'b1);
		send_item(MODE_UNUSED, 9'd511, 4'd15, 1'b1);
		send_item(M_ALLOC, 9'd0, 4'd1, 1'b0);
		send_item(M_ALLOC, 9'd0, 4'd2, 1'b1);
		send_item(M_ALLOC, 9'd200, 4'd4, 1'b0);
		send_item(M_ALLOC, 9'd200, 4'd5, 1'b0);
		send_item(M_QUERY, 9'd193, 4'd0, 1'b0);
		send_item(M_QUERY, 9'd455, 4'd8, 1'b1);
		send_item(M_ALLOC, 9'd0, 4'd3, 1'b0);
		drain();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			maybe_idle(!(n >= 300 && n < 450));
			random_request();
			if (n % 200 == 199)
				drain();
		end
		drain();
		repeat (40) @(negedge clk);

		$display("Requests sent: %0d allocate, %0d toggle, %0d query, %0d unused mode",
				mode_seen[M_ALLOC], mode_seen[M_TOGGLE], mode_seen[M_QUERY],
				mode_seen[MODE_UNUSED]);
		$display("Results compared: %0d, with %0d no-run and %0d state-mismatch outcomes",
				checked_count, no_run_seen, mismatch_seen);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
